/* hdl/rcsh_pkg.sv */
// shared types and constants for the range check slice histogram block
`default_nettype none

package rcsh_pkg;

    // slice geometry
    localparam int SLICE_BITS      = 16;
    localparam int NUM_SLOTS       = 8;
    localparam int NUM_FIXED       = 7;
    localparam int MAX_BITS        = 128;
    localparam int VALUE_BITS      = 128;
    localparam int SLOT_IDX_BITS   = 3;
    localparam int BITS_WIDTH      = 5;
    localparam int NUM_SOURCES     = 6;

    // histogram geometry
    localparam int TABLE_ADDR_BITS = 16;
    localparam int TABLE_DEPTH     = 65536;
    localparam int WIDTH_ENTRIES   = 17;

    // word kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // read table selects
    localparam logic [3:0] SEL_SLOT_FIRST = 4'd0;
    localparam logic [3:0] SEL_SLOT_LAST  = 4'd7;
    localparam logic [3:0] SEL_WIDTH      = 4'd8;
    localparam logic [3:0] SEL_DIFF       = 4'd9;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_DONE
    } rcsh_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic lookup;
        logic update;
        logic emit;
    } rcsh_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } rcsh_status_t;

endpackage

`default_nettype wire

/* hdl/range_check_slice_histogram.sv */
// top level of the range check slice histogram block
`default_nettype none

// A word is taken only in the idle state. It is decomposed into 16-bit slices as
// it is taken, then all nine histogram memories (eight slot tables and the
// difference table) are read together with registered read data, the saturating
// counts are written back in the next cycle, and the result is loaded into the
// output register once that register is free or being taken; only then is the
// next word accepted. A new word is taken while a finished result still waits in
// the output register. After reset a clearing pass zeroes all 65536 entries of
// the histogram memories, one entry of every table per cycle; in_stall stays high
// until it is done. A read word returns one count in count_read, saturated to 32
// bits, with every other field zero; an event word returns its slices with
// count_read zero.
module range_check_slice_histogram #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [63:0] clock_stamp,
    input  wire logic [63:0] value_low,
    input  wire logic [63:0] value_high,
    input  wire logic [7:0]  bit_count,
    input  wire logic [2:0]  emitter,
    input  wire logic [3:0]  table_select,
    input  wire logic [15:0] table_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      stamp_out,
    output logic [63:0]      echo_value_low,
    output logic [63:0]      echo_value_high,
    output logic [63:0]      fixed_slices_low,
    output logic [47:0]      fixed_slices_high,
    output logic [15:0]      dynamic_slice,
    output logic [4:0]       dynamic_bits,
    output logic [15:0]      slice_difference,
    output logic [7:0]       slot_flag,
    output logic [5:0]       source_flags,
    output logic [31:0]      count_read
);

    rcsh_pkg::rcsh_cmd_t    cmd;
    rcsh_pkg::rcsh_status_t status;

    // sequencing
    rcsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // decomposition and histograms
    rcsh_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .kind              (kind),
        .clock_stamp       (clock_stamp),
        .value_low         (value_low),
        .value_high        (value_high),
        .bit_count         (bit_count),
        .emitter           (emitter),
        .table_select      (table_select),
        .table_index       (table_index),
        .stamp_out         (stamp_out),
        .echo_value_low    (echo_value_low),
        .echo_value_high   (echo_value_high),
        .fixed_slices_low  (fixed_slices_low),
        .fixed_slices_high (fixed_slices_high),
        .dynamic_slice     (dynamic_slice),
        .dynamic_bits      (dynamic_bits),
        .slice_difference  (slice_difference),
        .slot_flag         (slot_flag),
        .source_flags      (source_flags),
        .count_read        (count_read)
    );

endmodule

`default_nettype wire

/* hdl/rcsh_datapath.sv */
// datapath: slice decomposition, histogram memories and result registers
`default_nettype none

module rcsh_datapath #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rcsh_pkg::rcsh_cmd_t     cmd,
    output rcsh_pkg::rcsh_status_t       status,
    input  wire logic                    kind,
    input  wire logic [63:0]             clock_stamp,
    input  wire logic [63:0]             value_low,
    input  wire logic [63:0]             value_high,
    input  wire logic [7:0]              bit_count,
    input  wire logic [2:0]              emitter,
    input  wire logic [3:0]              table_select,
    input  wire logic [15:0]             table_index,
    output logic [63:0]                  stamp_out,
    output logic [63:0]                  echo_value_low,
    output logic [63:0]                  echo_value_high,
    output logic [63:0]                  fixed_slices_low,
    output logic [47:0]                  fixed_slices_high,
    output logic [15:0]                  dynamic_slice,
    output logic [4:0]                   dynamic_bits,
    output logic [15:0]                  slice_difference,
    output logic [7:0]                   slot_flag,
    output logic [5:0]                   source_flags,
    output logic [31:0]                  count_read
);

    localparam int SB   = rcsh_pkg::SLICE_BITS;
    localparam int NS   = rcsh_pkg::NUM_SLOTS;
    localparam int NF   = rcsh_pkg::NUM_FIXED;
    localparam int AB   = rcsh_pkg::TABLE_ADDR_BITS;
    localparam int SIB  = rcsh_pkg::SLOT_IDX_BITS;
    localparam int BW   = rcsh_pkg::BITS_WIDTH;
    localparam int NSRC = rcsh_pkg::NUM_SOURCES;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // decomposition of the incoming word
    logic [rcsh_pkg::VALUE_BITS-1:0] value_in;
    logic [7:0]     nb_clamp;
    logic [7:0]     nb_minus;
    logic [SIB-1:0] fixed_cnt;
    logic [7:0]     nb_used;
    logic [BW-1:0]  dyn_bits_in;
    logic [SB-1:0]  slices_in [NS];
    logic [SB-1:0]  dyn_slice_in;
    logic [SB:0]    diff_wide;
    logic [NS-1:0]  slot_in;
    logic [NS-1:0]  lane_en_in;
    logic [NSRC-1:0] source_in;

    always_comb
    begin
        value_in    = {value_high, value_low};
        nb_clamp    = (bit_count > 8'(rcsh_pkg::MAX_BITS)) ? 8'(rcsh_pkg::MAX_BITS) : bit_count;
        nb_minus    = nb_clamp - 8'd1;
        fixed_cnt   = (nb_clamp > 8'(SB)) ? SIB'(nb_minus / 8'(SB)) : '0;
        nb_used     = 8'(fixed_cnt) * 8'(SB);
        dyn_bits_in = BW'(nb_clamp - nb_used);
        for (int p = 0; p < NS; p++)
        begin
            slices_in[p] = value_in[p*SB +: SB];
        end
        dyn_slice_in = slices_in[fixed_cnt];
        diff_wide    = ((SB+1)'(1) << dyn_bits_in) - (SB+1)'(dyn_slice_in) - (SB+1)'(1);
        slot_in      = NS'(1) << fixed_cnt;
        for (int p = 0; p < NS; p++)
        begin
            lane_en_in[p] = (p == NS - 1) || (SIB'(p) < fixed_cnt);
        end
        source_in = (emitter < 3'(NSRC)) ? NSRC'(1) << emitter : '0;
    end

    // working registers for the word in flight
    logic           kind_reg;
    logic [63:0]    stamp_reg;
    logic [63:0]    value_lo_reg;
    logic [63:0]    value_hi_reg;
    logic [SB-1:0]  fixed_reg [NF];
    logic [SB-1:0]  dyn_slice_reg;
    logic [BW-1:0]  dyn_bits_reg;
    logic [SB-1:0]  diff_reg;
    logic [NS-1:0]  slot_reg;
    logic [NS-1:0]  lane_en_reg;
    logic [NSRC-1:0] source_reg;
    logic [3:0]     sel_reg;
    logic [AB-1:0]  index_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= kind;
            stamp_reg     <= clock_stamp;
            value_lo_reg  <= value_low;
            value_hi_reg  <= value_high;
            for (int p = 0; p < NF; p++)
            begin
                fixed_reg[p] <= lane_en_in[p] ? slices_in[p] : '0;
            end
            dyn_slice_reg <= dyn_slice_in;
            dyn_bits_reg  <= dyn_bits_in;
            diff_reg      <= diff_wide[SB-1:0];
            slot_reg      <= slot_in;
            lane_en_reg   <= lane_en_in;
            source_reg    <= source_in;
            sel_reg       <= table_select;
            index_reg     <= table_index;
        end
    end

    // clearing sweep address after reset
    logic [AB-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clear_addr_reg <= clear_addr_reg + AB'(1);
        end
    end

    assign status.clear_last = &clear_addr_reg;

    logic is_event;
    assign is_event = (kind_reg == rcsh_pkg::KIND_EVENT);

    // slot histogram memories, one per slot table
    logic [COUNT_BITS-1:0] slot_rdata_reg [NS];

    for (genvar p = 0; p < NS; p++)
    begin : g_slot
        logic [COUNT_BITS-1:0] slot_mem [rcsh_pkg::TABLE_DEPTH];
        logic [AB-1:0]         lane_addr;
        logic [AB-1:0]         raddr;
        logic [AB-1:0]         waddr;
        logic                  we;
        logic [COUNT_BITS-1:0] wdata;

        if (p < NF)
        begin : g_fixed
            assign lane_addr = fixed_reg[p];
        end
        else
        begin : g_dyn
            assign lane_addr = dyn_slice_reg;
        end

        assign raddr = is_event ? lane_addr : index_reg;
        assign we    = cmd.clear_wr || (cmd.update && is_event && lane_en_reg[p]);
        assign waddr = cmd.clear_wr ? clear_addr_reg : lane_addr;
        assign wdata = cmd.clear_wr ? '0
                     : ((&slot_rdata_reg[p]) ? slot_rdata_reg[p]
                                             : slot_rdata_reg[p] + COUNT_ONE);

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                slot_mem[waddr] <= wdata;
            end
            if (cmd.lookup)
            begin
                slot_rdata_reg[p] <= slot_mem[raddr];
            end
        end
    end

    // difference histogram memory
    logic [COUNT_BITS-1:0] diff_mem [rcsh_pkg::TABLE_DEPTH];
    logic [COUNT_BITS-1:0] diff_rdata_reg;
    logic [AB-1:0]         diff_raddr;
    logic [AB-1:0]         diff_waddr;
    logic                  diff_we;
    logic [COUNT_BITS-1:0] diff_wdata;

    assign diff_raddr = is_event ? diff_reg : index_reg;
    assign diff_we    = cmd.clear_wr || (cmd.update && is_event);
    assign diff_waddr = cmd.clear_wr ? clear_addr_reg : diff_reg;
    assign diff_wdata = cmd.clear_wr ? '0
                      : ((&diff_rdata_reg) ? diff_rdata_reg : diff_rdata_reg + COUNT_ONE);

    always_ff @(posedge clk)
    begin
        if (diff_we)
        begin
            diff_mem[diff_waddr] <= diff_wdata;
        end
        if (cmd.lookup)
        begin
            diff_rdata_reg <= diff_mem[diff_raddr];
        end
    end

    // width histogram in flops, cleared by reset
    logic [COUNT_BITS-1:0] width_reg [rcsh_pkg::WIDTH_ENTRIES];
    logic [BW-1:0]         width_addr;
    logic                  width_hit;
    logic [COUNT_BITS-1:0] width_cur;

    always_comb
    begin
        width_addr = is_event ? dyn_bits_reg : index_reg[BW-1:0];
        width_hit  = is_event || (index_reg < AB'(rcsh_pkg::WIDTH_ENTRIES));
        width_cur  = '0;
        if (width_hit)
        begin
            width_cur = width_reg[width_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rcsh_pkg::WIDTH_ENTRIES; i++)
            begin
                width_reg[i] <= '0;
            end
        end
        else if (cmd.update && is_event && !(&width_cur))
        begin
            width_reg[width_addr] <= width_cur + COUNT_ONE;
        end
    end

    // count selection for read words
    logic [COUNT_BITS-1:0] count_sel;
    logic [COUNT_BITS-1:0] count_reg;

    always_comb
    begin
        case (sel_reg) inside
            [rcsh_pkg::SEL_SLOT_FIRST:rcsh_pkg::SEL_SLOT_LAST]:
                count_sel = slot_rdata_reg[sel_reg[SIB-1:0]];
            rcsh_pkg::SEL_WIDTH: count_sel = width_cur;
            rcsh_pkg::SEL_DIFF:  count_sel = diff_rdata_reg;
            default:             count_sel = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            count_reg <= count_sel;
        end
    end

    // result registers
    logic [63:0] count_wide;
    logic [63:0] fixed_lo_pack;
    logic [47:0] fixed_hi_pack;

    always_comb
    begin
        count_wide    = 64'(count_reg);
        fixed_lo_pack = {fixed_reg[3], fixed_reg[2], fixed_reg[1], fixed_reg[0]};
        fixed_hi_pack = {fixed_reg[6], fixed_reg[5], fixed_reg[4]};
    end

    logic [63:0] stamp_out_reg;
    logic [63:0] echo_lo_reg;
    logic [63:0] echo_hi_reg;
    logic [63:0] fixed_lo_reg;
    logic [47:0] fixed_hi_reg;
    logic [15:0] dyn_slice_out_reg;
    logic [4:0]  dyn_bits_out_reg;
    logic [15:0] diff_out_reg;
    logic [7:0]  slot_out_reg;
    logic [5:0]  source_out_reg;
    logic [31:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            stamp_out_reg     <= is_event ? stamp_reg     : '0;
            echo_lo_reg       <= is_event ? value_lo_reg  : '0;
            echo_hi_reg       <= is_event ? value_hi_reg  : '0;
            fixed_lo_reg      <= is_event ? fixed_lo_pack : '0;
            fixed_hi_reg      <= is_event ? fixed_hi_pack : '0;
            dyn_slice_out_reg <= is_event ? dyn_slice_reg : '0;
            dyn_bits_out_reg  <= is_event ? dyn_bits_reg  : '0;
            diff_out_reg      <= is_event ? diff_reg      : '0;
            slot_out_reg      <= is_event ? slot_reg      : '0;
            source_out_reg    <= is_event ? source_reg    : '0;
            if (is_event)
            begin
                count_out_reg <= '0;
            end
            else
            begin
                count_out_reg <= (count_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                       : count_wide[31:0];
            end
        end
    end

    assign stamp_out         = stamp_out_reg;
    assign echo_value_low    = echo_lo_reg;
    assign echo_value_high   = echo_hi_reg;
    assign fixed_slices_low  = fixed_lo_reg;
    assign fixed_slices_high = fixed_hi_reg;
    assign dynamic_slice     = dyn_slice_out_reg;
    assign dynamic_bits      = dyn_bits_out_reg;
    assign slice_difference  = diff_out_reg;
    assign slot_flag         = slot_out_reg;
    assign source_flags      = source_out_reg;
    assign count_read        = count_out_reg;

endmodule

`default_nettype wire

/* hdl/rcsh_ctrl.sv */
// controller: clearing sweep, per-word sequencing and output handshake
`default_nettype none

module rcsh_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output rcsh_pkg::rcsh_cmd_t         cmd,
    input  wire rcsh_pkg::rcsh_status_t status
);

    rcsh_pkg::rcsh_state_t state_reg;
    rcsh_pkg::rcsh_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcsh_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            rcsh_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = rcsh_pkg::ST_IDLE;
                end
            end
            rcsh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rcsh_pkg::ST_LOOKUP;
                end
            end
            rcsh_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = rcsh_pkg::ST_UPDATE;
            end
            rcsh_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = rcsh_pkg::ST_DONE;
            end
            rcsh_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rcsh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcsh_pkg::ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = (state_reg != rcsh_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // an accepted word always starts a lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == rcsh_pkg::ST_LOOKUP)
        else $error("accepted word did not start a lookup");

    // the read-modify-write never skips its write back
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rcsh_pkg::ST_LOOKUP |=> state_reg == rcsh_pkg::ST_UPDATE)
        else $error("lookup not followed by update");

    // no result appears while the histograms are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rcsh_pkg::ST_CLEAR |-> !out_valid)
        else $error("output valid during clearing sweep");

    // a taken word with nothing new behind it empties the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && state_reg != rcsh_pkg::ST_DONE |=> !out_valid)
        else $error("output word repeated");
`endif

endmodule

`default_nettype wire

/* dv/range_check_slice_histogram_tb.sv */
// testbench for the range check slice histogram block: slicing, source flags, histogram reads
module range_check_slice_histogram_tb;

    localparam int RANDOM_WORDS   = 1450;
    localparam int BURST_WORDS    = 160;
    localparam int IDLE_PERCENT   = 11;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [31:0]  COUNT_FULL     = 32'hFFFF_FFFF;
    localparam logic [3:0]   SEL_UNUSED_LOW = 4'd10;
    localparam logic [3:0]   SEL_UNUSED_TOP = 4'd15;
    localparam logic [127:0] ALL_ONES       = '1;
    localparam logic [127:0] ALTERNATING    = {8{16'h5555}};

    typedef enum logic [2:0] {
        SRC_ALU,
        SRC_MEMORY,
        SRC_GAS_L2,
        SRC_GAS_DA,
        SRC_CMP_LO,
        SRC_CMP_HI,
        SRC_SPARE_LO,
        SRC_SPARE_HI
    } source_e;

    typedef struct packed {
        logic        kind;
        logic [63:0] clock_stamp;
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic [7:0]  bit_count;
        logic [2:0]  emitter;
        logic [3:0]  table_select;
        logic [15:0] table_index;
    } rc_word_t;

    typedef struct packed {
        logic [63:0] stamp_out;
        logic [63:0] echo_value_low;
        logic [63:0] echo_value_high;
        logic [63:0] fixed_slices_low;
        logic [47:0] fixed_slices_high;
        logic [15:0] dynamic_slice;
        logic [4:0]  dynamic_bits;
        logic [15:0] slice_difference;
        logic [7:0]  slot_flag;
        logic [5:0]  source_flags;
        logic [31:0] count_read;
    } rc_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [63:0] clock_stamp;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [7:0]  bit_count;
    logic [2:0]  emitter;
    logic [3:0]  table_select;
    logic [15:0] table_index;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] stamp_out;
    logic [63:0] echo_value_low;
    logic [63:0] echo_value_high;
    logic [63:0] fixed_slices_low;
    logic [47:0] fixed_slices_high;
    logic [15:0] dynamic_slice;
    logic [4:0]  dynamic_bits;
    logic [15:0] slice_difference;
    logic [7:0]  slot_flag;
    logic [5:0]  source_flags;
    logic [31:0] count_read;

    // shadow histograms, cleared like the block after reset
    int unsigned  slot_hist [rcsh_pkg::NUM_SLOTS][rcsh_pkg::TABLE_DEPTH];
    int unsigned  width_hist [rcsh_pkg::WIDTH_ENTRIES];
    int unsigned  diff_hist [rcsh_pkg::TABLE_DEPTH];

    rc_result_t   pending_results [$];
    rc_result_t   last_event = '0;
    logic [127:0] hot_values [4];
    int           idle_pct = IDLE_PERCENT;
    int           mismatch_count = 0;
    int           idle_cycles = 0;

    range_check_slice_histogram i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .clock_stamp       (clock_stamp),
        .value_low         (value_low),
        .value_high        (value_high),
        .bit_count         (bit_count),
        .emitter           (emitter),
        .table_select      (table_select),
        .table_index       (table_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .stamp_out         (stamp_out),
        .echo_value_low    (echo_value_low),
        .echo_value_high   (echo_value_high),
        .fixed_slices_low  (fixed_slices_low),
        .fixed_slices_high (fixed_slices_high),
        .dynamic_slice     (dynamic_slice),
        .dynamic_bits      (dynamic_bits),
        .slice_difference  (slice_difference),
        .slot_flag         (slot_flag),
        .source_flags      (source_flags),
        .count_read        (count_read)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // saturating histogram increment
    function automatic int unsigned bumped(input int unsigned c);
        return (c == COUNT_FULL) ? c : c + 1;
    endfunction

    // expected result of one word, updating the shadow histograms on events
    function automatic rc_result_t slice_and_count(input rc_word_t w);
        rc_result_t   r;
        logic [127:0] v;
        logic [111:0] fixed;
        logic [15:0]  s;
        logic [31:0]  c;
        int           nb;
        int           diff;
        r = '0;
        if (w.kind == rcsh_pkg::KIND_READ)
        begin
            c = '0;
            if (w.table_select < rcsh_pkg::NUM_SLOTS)
                c = slot_hist[w.table_select[2:0]][w.table_index];
            else if (w.table_select == rcsh_pkg::SEL_WIDTH)
                c = (w.table_index < rcsh_pkg::WIDTH_ENTRIES)
                  ? width_hist[w.table_index[4:0]] : '0;
            else if (w.table_select == rcsh_pkg::SEL_DIFF)
                c = diff_hist[w.table_index];
            r.count_read = c;
            return r;
        end
        v     = {w.value_high, w.value_low};
        nb    = (w.bit_count > rcsh_pkg::MAX_BITS) ? rcsh_pkg::MAX_BITS : int'(w.bit_count);
        fixed = '0;
        r.stamp_out       = w.clock_stamp;
        r.echo_value_low  = w.value_low;
        r.echo_value_high = w.value_high;
        // full slices go to fixed positions, the rest becomes the dynamic slice
        for (int i = 0; i < rcsh_pkg::NUM_SLOTS; i++)
        begin
            s = v[15:0];
            if (nb <= rcsh_pkg::SLICE_BITS)
            begin
                r.dynamic_slice = s;
                r.dynamic_bits  = 5'(nb);
                r.slot_flag     = 8'(1 << i);
                slot_hist[rcsh_pkg::NUM_SLOTS - 1][s] =
                    bumped(slot_hist[rcsh_pkg::NUM_SLOTS - 1][s]);
                break;
            end
            fixed[rcsh_pkg::SLICE_BITS * i +: rcsh_pkg::SLICE_BITS] = s;
            slot_hist[i][s] = bumped(slot_hist[i][s]);
            nb -= rcsh_pkg::SLICE_BITS;
            v = v >> rcsh_pkg::SLICE_BITS;
        end
        diff = (1 << r.dynamic_bits) - int'(r.dynamic_slice) - 1;
        r.slice_difference  = diff[15:0];
        r.fixed_slices_low  = fixed[63:0];
        r.fixed_slices_high = fixed[111:64];
        r.source_flags      = (w.emitter <= SRC_CMP_HI) ? 6'(1 << w.emitter) : '0;
        width_hist[r.dynamic_bits]     = bumped(width_hist[r.dynamic_bits]);
        diff_hist[r.slice_difference] = bumped(diff_hist[r.slice_difference]);
        last_event = r;
        return r;
    endfunction

    function automatic logic [127:0] rand_value();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // event word; the read fields carry junk
    function automatic rc_word_t event_word(input logic [127:0] value, input logic [7:0] nb,
                                            input logic [2:0] src);
        rc_word_t w;
        w.kind         = rcsh_pkg::KIND_EVENT;
        w.clock_stamp  = {$urandom, $urandom};
        {w.value_high, w.value_low} = value;
        w.bit_count    = nb;
        w.emitter      = src;
        w.table_select = 4'($urandom);
        w.table_index  = 16'($urandom);
        return w;
    endfunction

    // read word; the event fields carry junk
    function automatic rc_word_t read_word(input logic [3:0] sel, input logic [15:0] idx);
        rc_word_t w;
        w = event_word(rand_value(), 8'($urandom), 3'($urandom));
        w.kind         = rcsh_pkg::KIND_READ;
        w.table_select = sel;
        w.table_index  = idx;
        return w;
    endfunction

    // mostly events, some over a few hot values; reads partly aimed at entries the last event bumped
    function automatic rc_word_t random_word();
        logic [127:0] value;
        logic [111:0] fixed;
        logic [15:0]  idx;
        logic [7:0]   nb;
        int unsigned  roll;
        int unsigned  pick;
        roll = $urandom_range(99);
        if (roll < 18)
        begin
            pick  = $urandom_range(rcsh_pkg::SEL_DIFF);
            fixed = {last_event.fixed_slices_high, last_event.fixed_slices_low};
            if (pick < rcsh_pkg::NUM_FIXED)
                idx = fixed[rcsh_pkg::SLICE_BITS * pick +: rcsh_pkg::SLICE_BITS];
            else if (pick == rcsh_pkg::SEL_SLOT_LAST)
                idx = last_event.dynamic_slice;
            else if (pick == rcsh_pkg::SEL_WIDTH)
                idx = 16'(last_event.dynamic_bits);
            else
                idx = last_event.slice_difference;
            return read_word(4'(pick), idx);
        end
        if (roll < 30)
        begin
            idx = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(20));
            return read_word(4'($urandom), idx);
        end
        case ($urandom_range(3))
            0: value = hot_values[$urandom_range(3)];
            1: value = rand_value() >> $urandom_range(127);
            default: value = rand_value();
        endcase
        roll = $urandom_range(99);
        if (roll < 60)
            nb = 8'($urandom_range(rcsh_pkg::MAX_BITS));
        else if (roll < 85)
            nb = 8'(rcsh_pkg::SLICE_BITS * $urandom_range(rcsh_pkg::NUM_SLOTS)
                    + $urandom_range(1));
        else
            nb = 8'($urandom_range(255, rcsh_pkg::MAX_BITS + 1));
        return event_word(value, nb, 3'($urandom));
    endfunction

    // drive one word and hold it until accepted
    task automatic send_word(input rc_word_t w);
        rc_result_t expected;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= w.kind;
        clock_stamp  <= w.clock_stamp;
        value_low    <= w.value_low;
        value_high   <= w.value_high;
        bit_count    <= w.bit_count;
        emitter      <= w.emitter;
        table_select <= w.table_select;
        table_index  <= w.table_index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected        = slice_and_count(w);
        pending_results = {pending_results, expected};
    endtask

    // bit count extremes, slot boundaries and clamping
    task automatic test_width_corners();
        send_word(event_word('0, 8'd0, SRC_ALU));
        send_word(event_word(ALL_ONES, 8'd1, SRC_MEMORY));
        send_word(event_word(ALL_ONES, 8'd16, SRC_GAS_L2));
        send_word(event_word(ALL_ONES, 8'd17, SRC_GAS_DA));
        send_word(event_word(ALL_ONES, 8'd112, SRC_CMP_LO));
        send_word(event_word(ALL_ONES, 8'd113, SRC_CMP_HI));
        send_word(event_word(ALL_ONES, 8'd128, SRC_ALU));
        send_word(event_word(ALTERNATING, 8'd129, SRC_MEMORY));
        send_word(event_word(rand_value(), 8'd255, SRC_ALU));
    endtask

    // one event per source code, including the two unused ones
    task automatic test_source_flags();
        source_e src;
        src = src.first();
        repeat (src.num())
        begin
            send_word(event_word(rand_value(), 8'($urandom_range(rcsh_pkg::MAX_BITS)), src));
            src = src.next();
        end
    endtask

    // reads of every kind of table, out of range selects and indexes
    task automatic test_table_reads();
        send_word(read_word(rcsh_pkg::SEL_SLOT_FIRST, 16'hFFFF));
        send_word(read_word(rcsh_pkg::SEL_SLOT_LAST, 16'hFFFF));
        send_word(read_word(rcsh_pkg::SEL_WIDTH, 16'd16));
        send_word(read_word(rcsh_pkg::SEL_WIDTH, 16'd17));
        send_word(read_word(rcsh_pkg::SEL_WIDTH, 16'hFFFF));
        send_word(read_word(rcsh_pkg::SEL_DIFF, 16'd0));
        send_word(read_word(SEL_UNUSED_LOW, 16'd0));
        send_word(read_word(SEL_UNUSED_TOP, 16'hFFFF));
    endtask

    // random events and reads with idling on both sides
    task automatic test_random_mix();
        hot_values[0] = ALL_ONES;
        for (int i = 1; i < 4; i++)
            hot_values[i] = rand_value();
        repeat (RANDOM_WORDS)
            send_word(random_word());
    endtask

    // back to back words with neither side idling
    task automatic test_full_rate();
        idle_pct = 0;
        repeat (BURST_WORDS)
            send_word(random_word());
        idle_pct = IDLE_PERCENT;
    endtask

    // random back pressure on the result side
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        rc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $error("result word with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("stamp_out", want.stamp_out, stamp_out);
                check_field("echo_value_low", want.echo_value_low, echo_value_low);
                check_field("echo_value_high", want.echo_value_high, echo_value_high);
                check_field("fixed_slices_low", want.fixed_slices_low, fixed_slices_low);
                check_field("fixed_slices_high", want.fixed_slices_high, fixed_slices_high);
                check_field("dynamic_slice", want.dynamic_slice, dynamic_slice);
                check_field("dynamic_bits", want.dynamic_bits, dynamic_bits);
                check_field("slice_difference", want.slice_difference, slice_difference);
                check_field("slot_flag", want.slot_flag, slot_flag);
                check_field("source_flags", want.source_flags, source_flags);
                check_field("count_read", want.count_read, count_read);
            end
        end
    end

    // watchdog on cycles without any handshake, covers the clearing pass
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // reset, tests in turn, drain and verdict
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        kind         <= rcsh_pkg::KIND_EVENT;
        clock_stamp  <= '0;
        value_low    <= '0;
        value_high   <= '0;
        bit_count    <= '0;
        emitter      <= '0;
        table_select <= '0;
        table_index  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_width_corners();
        test_source_flags();
        test_table_reads();
        test_random_mix();
        test_full_rate();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
